// ===== design/rmsd_pkg.sv =====
`default_nettype none
package rmsd_pkg;

    localparam int MAX_LEN    = 1024;
    localparam int VAL_W      = 16;
    localparam int TERM_W     = 2 * VAL_W;
    localparam int SUM_W      = 42;
    localparam int CNT_W      = 11;
    localparam int DIST_W     = 24;
    localparam int FRAC_SHIFT = 16;
    localparam int RAD_W      = SUM_W + FRAC_SHIFT;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQ_W       = ROOT_W + 3;
    localparam int STEP_W     = $clog2(SUM_W);

endpackage
`default_nettype wire

// ===== design/rms_or_mean_abs_distance.sv =====
`default_nettype none
// the pipeline drains after the last item, the divide and root run (skipped for a too-long
// vector) and the result is loaded, later while the result register is still full
// the shared compare-subtract unit runs a 42-step restoring divide then a 29-step square root
// throughput: one item per cycle within a vector; after a last item the input stalls until
// the result is loaded into the output register
// reset: aresetn synchronous active low clears accumulator, count, mode and output valid
module rms_or_mean_abs_distance
    import rmsd_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic                    cfg_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic signed [VAL_W-1:0] s_first_value,
    input  wire logic signed [VAL_W-1:0] s_second_value,
    input  wire logic                    s_last_element,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic        [DIST_W-1:0]     m_distance,
    output logic        [CNT_W-1:0]      m_element_count,
    output logic                         m_too_long
);

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic                mode_reg;
    logic                p1_valid_reg;
    logic                p1_mode_reg;
    logic [VAL_W-1:0]    p1_mag_reg;
    logic                p2_valid_reg;
    logic [TERM_W-1:0]   p2_term_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                ovf_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [SQ_W-1:0]     rem_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                m_valid_reg;
    logic [DIST_W-1:0]   m_distance_reg;
    logic [CNT_W-1:0]    m_count_reg;
    logic                m_too_long_reg;

    logic signed [VAL_W:0] diff;
    logic [VAL_W:0]        diff_abs;
    logic [VAL_W-1:0]      mag;
    logic                  s_accept;
    logic [SQ_W-1:0]       sub_a;
    logic [SQ_W-1:0]       sub_b;
    logic [SQ_W:0]         sub_diff;
    logic                  sub_ge;
    logic [SQ_W-1:0]       sub_res;
    logic [SUM_W-1:0]      quo_shift;
    logic [ROOT_W-1:0]     root_shift;

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == ST_ACCUM);
    assign s_accept        = s_valid && s_ready;
    assign m_valid         = m_valid_reg;
    assign m_distance      = m_distance_reg;
    assign m_element_count = m_count_reg;
    assign m_too_long      = m_too_long_reg;

    assign diff     = {s_first_value[VAL_W-1], s_first_value}
                    - {s_second_value[VAL_W-1], s_second_value};
    assign diff_abs = diff[VAL_W] ? (~diff + 1'b1) : diff;
    assign mag      = diff_abs[VAL_W-1:0];

    // shared compare-subtract: divide step or root step
    always_comb begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            ST_DIV: begin
                sub_a = SQ_W'({rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]});
                sub_b = SQ_W'(count_reg);
            end
            ST_SQRT: begin
                sub_a = {rem_reg[SQ_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
                sub_b = SQ_W'({root_reg, 2'b01});
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge     = ~sub_diff[SQ_W];
    assign sub_res    = sub_ge ? sub_diff[SQ_W-1:0] : sub_a;
    assign quo_shift  = {quo_reg[SUM_W-2:0], sub_ge};
    assign root_shift = {root_reg[ROOT_W-2:0], sub_ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_ACCUM;
            mode_reg     <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            step_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end

            // accumulate pipeline: magnitude, term, sum
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= p1_valid_reg;
            p2_term_reg  <= p1_mode_reg ? TERM_W'(p1_mag_reg) : p1_mag_reg * p1_mag_reg;
            if (p2_valid_reg) begin
                sum_reg <= sum_reg + SUM_W'(p2_term_reg);
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_ACCUM: begin
                    if (s_accept) begin
                        if (count_reg >= CNT_W'(MAX_LEN)) begin
                            ovf_reg   <= 1'b1;
                            count_reg <= CNT_W'(MAX_LEN + 1);
                        end else begin
                            count_reg    <= count_reg + 1'b1;
                            p1_valid_reg <= 1'b1;
                            p1_mag_reg   <= mag;
                            p1_mode_reg  <= mode_reg;
                        end
                        if (s_last_element) begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!p1_valid_reg && !p2_valid_reg) begin
                        sum_reg  <= '0;
                        quo_reg  <= sum_reg;
                        rem_reg  <= '0;
                        root_reg <= '0;
                        step_reg <= '0;
                        state_reg <= ovf_reg ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= sub_res;
                    quo_reg  <= quo_shift;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(SUM_W - 1)) begin
                        rad_reg   <= {quo_shift, {FRAC_SHIFT{1'b0}}};
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    rem_reg  <= sub_res;
                    root_reg <= root_shift;
                    rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(ROOT_W - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_distance_reg <= ovf_reg ? '0 : root_reg[DIST_W-1:0];
                        m_count_reg    <= ovf_reg ? '0 : count_reg;
                        m_too_long_reg <= ovf_reg;
                        count_reg      <= '0;
                        ovf_reg        <= 1'b0;
                        state_reg      <= ST_ACCUM;
                    end
                end
                default: begin
                    state_reg <= ST_ACCUM;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
